@@ design/lifetime_buffer_allocator_top_assert.svh @@
// ---------------------------------------------------------------------------
// lifetime buffer allocator assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef LIFETIME_BUFFER_ALLOCATOR_TOP_ASSERT_SVH
`define LIFETIME_BUFFER_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lba check failed");
`define LBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lba check failed");
`else
`define LBA_ASSERT_IMPL(lbl, ante, cons)
`define LBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/lba_pkg.sv @@
// ---------------------------------------------------------------------------
// lba_pkg
// types and constants shared by the lifetime buffer allocator
// ---------------------------------------------------------------------------
package lba_pkg;

  localparam int ACTION_W   = 2;
  localparam int UNIT_W     = 15;
  localparam int TGT_W      = 6;
  localparam int GRANT_W    = 6;
  localparam int COUNT_W    = 7;
  // widest table address over the supported depth range
  localparam int ADDR_MAX_W = 10;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [UNIT_W-1:0]   unit_index;
    logic                allow_alias;
    logic [TGT_W-1:0]    target_buffer;
  } lba_req_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_buffer;
    logic [COUNT_W-1:0] used_buffers;
    logic               table_full;
  } lba_rsp_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [UNIT_W-1:0]     data;
  } lba_mem_wr_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
  } lba_mem_rd_t;

endpackage

@@ design/lba_chan_if.sv @@
// ---------------------------------------------------------------------------
// lba_chan_if
// valid/ready channel carrying one item of a given payload type
// ---------------------------------------------------------------------------
interface lba_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/lba_mem.sv @@
// ---------------------------------------------------------------------------
// lba_mem
// last-use table: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module lba_mem
  import lba_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  lba_mem_wr_t       wr,
  input  lba_mem_rd_t       rd,
  output logic [UNIT_W-1:0] rd_data
);

  localparam int IW = $clog2(DEPTH);

  logic [UNIT_W-1:0] mem [DEPTH];
  logic [UNIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[IW'(wr.addr)] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[IW'(rd.addr)];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/lba_ctrl.sv @@
// ---------------------------------------------------------------------------
// lba_ctrl
// request sequencer: table scan, append, set and clear, buffer count
// ---------------------------------------------------------------------------
`include "lifetime_buffer_allocator_top_assert.svh"

module lba_ctrl
  import lba_pkg::*;
#(
  parameter int MAX_BUFFERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lba_req_t          in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output lba_rsp_t          res_data,
  output lba_mem_wr_t       mem_wr,
  output lba_mem_rd_t       mem_rd,
  input  logic [UNIT_W-1:0] mem_rd_data
);

  localparam int IW = $clog2(MAX_BUFFERS);
  localparam int CW = $clog2(MAX_BUFFERS + 1);
  localparam int WW = (CW > TGT_W) ? CW : TGT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          chk_valid_r, chk_valid_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  lba_req_t      req_r, req_nxt;
  logic [IW-1:0] grant_r, grant_nxt;
  logic          full_r, full_nxt;

  logic          hit;
  logic          target_ok;

  assign target_ok = WW'(in_data.target_buffer) < WW'(total_r);

  // compare the entry read in the previous cycle
  assign hit = chk_valid_r &&
               (req_r.allow_alias ? (mem_rd_data <= req_r.unit_index)
                                  : (mem_rd_data <  req_r.unit_index));

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    scan_idx_nxt  = scan_idx_r;
    chk_valid_nxt = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    req_nxt       = req_r;
    grant_nxt     = grant_r;
    full_nxt      = full_r;
    mem_wr        = '0;
    mem_rd        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          grant_nxt = '0;
          full_nxt  = 1'b0;
          state_nxt = ST_RESP;
          case (in_data.action)
            ACT_ALLOC: begin
              scan_idx_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            ACT_SET: begin
              mem_wr.en   = target_ok;
              mem_wr.addr = ADDR_MAX_W'(in_data.target_buffer);
              mem_wr.data = in_data.unit_index;
            end
            ACT_CLEAR: begin
              total_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          grant_nxt = chk_idx_r;
          full_nxt  = 1'b0;
          state_nxt = ST_RESP;
        end else if (scan_idx_r == total_r) begin
          // nothing reusable: append or report full
          if (total_r < CW'(MAX_BUFFERS)) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ADDR_MAX_W'(total_r);
            mem_wr.data = req_r.unit_index;
            grant_nxt   = IW'(total_r);
            total_nxt   = total_r + 1'b1;
            full_nxt    = 1'b0;
          end else begin
            grant_nxt = '0;
            full_nxt  = 1'b1;
          end
          state_nxt = ST_RESP;
        end else begin
          mem_rd.en     = 1'b1;
          mem_rd.addr   = ADDR_MAX_W'(scan_idx_r);
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = IW'(scan_idx_r);
          scan_idx_nxt  = scan_idx_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    req_r      <= req_nxt;
    grant_r    <= grant_nxt;
    full_r     <= full_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res_data  = '{granted_buffer: GRANT_W'(grant_r),
                       used_buffers:   COUNT_W'(total_r),
                       table_full:     full_r};

  `LBA_ASSERT_IMPL(a_total_bound, 1'b1, total_r <= CW'(MAX_BUFFERS))
  `LBA_ASSERT_IMPL(a_chk_in_scan, chk_valid_r, state_r == ST_SCAN)
  `LBA_ASSERT_IMPL(a_rd_in_table, mem_rd.en, scan_idx_r < total_r)
  `LBA_ASSERT_NEXT(a_clear_empties, in_valid && in_ready && in_data.action == ACT_CLEAR, total_r == '0)
  `LBA_ASSERT_IMPL(a_full_only_at_max, res_valid && full_r, total_r == CW'(MAX_BUFFERS))

endmodule

@@ design/lifetime_buffer_allocator_top.sv @@
// ---------------------------------------------------------------------------
// lifetime_buffer_allocator_top
// buffer reuse allocator over a last-use table held in a synchronous memory
// ---------------------------------------------------------------------------
// allocate: the table is scanned one entry per cycle from buffer 0; the first
//   reusable buffer is granted, else a new buffer is appended or full is reported
// set, clear and unused codes: no table scan between accept and result
// next item taken once the result has entered the output register
// synchronous active-low reset clears the buffer count, the sequencer state and the output valid; no table clearing
module lifetime_buffer_allocator_top
  import lba_pkg::*;
#(
  parameter int MAX_BUFFERS = 64
) (
  input logic        clk,
  input logic        rst_n,
  lba_chan_if.sink   in_ch,
  lba_chan_if.source out_ch
);

  lba_req_t          in_data;
  lba_rsp_t          res_data;
  logic              res_valid;
  logic              res_ready;
  logic              in_ready;
  lba_mem_wr_t       mem_wr;
  lba_mem_rd_t       mem_rd;
  logic [UNIT_W-1:0] mem_rd_data;

  logic              out_valid_r, out_valid_nxt;
  lba_rsp_t          out_data_r;

  assign in_data     = in_ch.data;
  assign in_ch.ready = in_ready;

  lba_ctrl #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_wr      (mem_wr),
    .mem_rd      (mem_rd),
    .mem_rd_data (mem_rd_data)
  );

  lba_mem #(
    .DEPTH (MAX_BUFFERS)
  ) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  // output register takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

@@ tb/lba_tb_pkg.sv @@
// ---------------------------------------------------------------------------
// lba_tb_pkg
// scoreboard for the lifetime buffer allocator: mirrors the last-use table
// and buffer count, predicts each response and checks it field by field
// ---------------------------------------------------------------------------
package lba_tb_pkg;
  import lba_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  class lba_scoreboard;
    logic [UNIT_W-1:0]  last_use_mirror [TABLE_DEPTH];
    int unsigned        tbl_entries;
    logic [GRANT_W-1:0] last_grant;
    lba_rsp_t           awaited_rsp [$];
    int unsigned        failures;

    function new();
      foreach (last_use_mirror[i]) last_use_mirror[i] = '0;
      tbl_entries = 0;
      last_grant  = '0;
      failures    = 0;
    endfunction

    // updates the mirrored table and returns the response the block owes
    function lba_rsp_t apply_request(lba_req_t req);
      lba_rsp_t rsp;
      bit       found;
      bit       fits;
      rsp   = '0;
      found = 1'b0;
      case (req.action)
        ACT_ALLOC: begin
          for (int unsigned i = 0; i < tbl_entries; i++) begin
            fits = req.allow_alias ? (last_use_mirror[i] <= req.unit_index)
                                   : (last_use_mirror[i] < req.unit_index);
            if (!found && fits) begin
              rsp.granted_buffer = GRANT_W'(i);
              found = 1'b1;
            end
          end
          if (!found) begin
            if (tbl_entries < TABLE_DEPTH) begin
              last_use_mirror[tbl_entries] = req.unit_index;
              rsp.granted_buffer = GRANT_W'(tbl_entries);
              tbl_entries++;
            end else begin
              rsp.table_full = 1'b1;
            end
          end
        end
        ACT_SET: begin
          // targets beyond the table are ignored
          if (req.target_buffer < tbl_entries)
            last_use_mirror[req.target_buffer] = req.unit_index;
        end
        ACT_CLEAR: begin
          tbl_entries = 0;
        end
        default: begin
        end
      endcase
      rsp.used_buffers = COUNT_W'(tbl_entries);
      return rsp;
    endfunction

    function void note_request(lba_req_t req);
      lba_rsp_t rsp;
      rsp = apply_request(req);
      last_grant = rsp.granted_buffer;
      awaited_rsp.insert(awaited_rsp.size(), rsp);
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      failures++;
    endtask

    task check_result(lba_rsp_t got);
      lba_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.granted_buffer !== want.granted_buffer)
        report_mismatch($sformatf("granted_buffer got %0d want %0d",
                                  got.granted_buffer, want.granted_buffer));
      if (got.used_buffers !== want.used_buffers)
        report_mismatch($sformatf("used_buffers got %0d want %0d",
                                  got.used_buffers, want.used_buffers));
      if (got.table_full !== want.table_full)
        report_mismatch($sformatf("table_full got %0b want %0b",
                                  got.table_full, want.table_full));
    endtask
  endclass

endpackage

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// drives allocate, set, clear and unused requests into the allocator under
// several idle and stall mixes, and checks every response in order
// ---------------------------------------------------------------------------
module tb_top;
  import lba_pkg::*;
  import lba_tb_pkg::*;

  localparam int          ITEM_TARGET  = 1150;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned UNIT_TOP     = (1 << UNIT_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  lba_chan_if #(.payload_t(lba_req_t)) req_ch ();
  lba_chan_if #(.payload_t(lba_rsp_t)) rsp_ch ();

  lifetime_buffer_allocator_top #(
    .MAX_BUFFERS(TABLE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  lba_scoreboard sb;
  int unsigned   send_idle;
  int unsigned   recv_stall;
  int unsigned   items_sent;
  int unsigned   cycle_count;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lifetime_buffer_allocator_top verification failed");
      $finish;
    end else if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.data);
    end
  end

  function automatic logic [UNIT_W-1:0] later_unit(int unsigned base, int unsigned step);
    return (base + step > UNIT_TOP) ? UNIT_W'(UNIT_TOP) : UNIT_W'(base + step);
  endfunction

  // entered and left at a falling edge; valid stays high into the next item
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [UNIT_W-1:0] unit,
                              input logic alias_ok,
                              input logic [TGT_W-1:0] tgt);
    lba_req_t req;
    req = '{action: act, unit_index: unit, allow_alias: alias_ok, target_buffer: tgt};
    if ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(req);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send_request(ACTION_W'($urandom_range(3)), UNIT_W'($urandom_range(UNIT_TOP)),
                 1'($urandom_range(1)), TGT_W'($urandom_range(63)));
  endtask

  task automatic run_directed();
    send_request(ACT_SET, 15'd5, 1'b0, 6'd0);        // set beyond an empty table
    send_request(ACT_UNUSED, 15'd0, 1'b0, 6'd0);
    send_request(ACT_ALLOC, 15'd0, 1'b0, 6'd0);      // first buffer
    send_request(ACT_ALLOC, 15'd0, 1'b1, 6'd0);      // reuse on equal index
    send_request(ACT_ALLOC, 15'd0, 1'b0, 6'd0);      // equal index refused
    send_request(ACT_SET, 15'h7fff, 1'b0, 6'd1);
    send_request(ACT_SET, 15'd0, 1'b1, 6'd63);       // beyond the table
    send_request(ACT_ALLOC, 15'h7fff, 1'b0, 6'd0);
    send_request(ACT_ALLOC, 15'h7fff, 1'b1, 6'd63);
    send_request(ACT_SET, 15'h7fff, 1'b0, 6'd0);
    send_request(ACT_ALLOC, 15'h7fff, 1'b0, 6'd0);   // nothing strictly earlier
    send_request(ACT_ALLOC, 15'h7fff, 1'b1, 6'd0);
    send_request(ACT_SET, 15'd100, 1'b0, 6'd0);
    send_request(ACT_ALLOC, 15'd100, 1'b0, 6'd0);
    send_request(ACT_ALLOC, 15'd100, 1'b1, 6'd0);
    send_request(ACT_SET, 15'd50, 1'b1, 6'd3);
    send_request(ACT_ALLOC, 15'd51, 1'b0, 6'd0);
    send_request(ACT_UNUSED, 15'h7fff, 1'b1, 6'd63);
    send_request(ACT_CLEAR, 15'h7fff, 1'b1, 6'd63);
    send_request(ACT_SET, 15'd9, 1'b0, 6'd0);        // ignored after clear
    send_request(ACT_ALLOC, 15'd7, 1'b0, 6'd0);
    send_request(ACT_CLEAR, 15'd0, 1'b0, 6'd0);
  endtask

  // index 0 without aliasing never reuses, so every allocate appends until full
  task automatic run_fill();
    send_request(ACT_CLEAR, UNIT_W'($urandom_range(UNIT_TOP)), 1'b0, 6'd0);
    while (sb.tbl_entries < TABLE_DEPTH) begin
      if (sb.tbl_entries > 0 && $urandom_range(3) == 0)
        send_request(ACT_SET, UNIT_W'($urandom_range(UNIT_TOP)), 1'($urandom_range(1)),
                     TGT_W'($urandom_range(sb.tbl_entries - 1)));
      else
        send_request(ACT_ALLOC, 15'd0, 1'b0, TGT_W'($urandom_range(63)));
    end
    repeat ($urandom_range(4, 12)) begin
      if ($urandom_range(2) == 0)
        send_request(ACT_SET, UNIT_W'($urandom_range(UNIT_TOP)), 1'b0,
                     TGT_W'($urandom_range(63)));
      else
        send_request(ACT_ALLOC, UNIT_W'($urandom_range(UNIT_TOP)), 1'($urandom_range(1)),
                     TGT_W'($urandom_range(63)));
    end
  endtask

  // walk the unit index upwards, often extending the life of the buffer just granted
  task automatic run_scan();
    int unsigned unit_now;
    int unsigned pick;
    int unsigned tgt_top;
    if ($urandom_range(1) == 0)
      send_request(ACT_CLEAR, 15'd0, 1'b0, TGT_W'($urandom_range(63)));
    unit_now = ($urandom_range(7) == 0) ? UNIT_TOP - $urandom_range(200)
                                        : $urandom_range(UNIT_TOP);
    repeat ($urandom_range(20, 80)) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_request(ACT_ALLOC, UNIT_W'(unit_now), 1'($urandom_range(1)),
                     TGT_W'($urandom_range(63)));
        if ($urandom_range(99) < 75)
          send_request(ACT_SET, later_unit(unit_now, $urandom_range(40)),
                       1'($urandom_range(1)), sb.last_grant);
      end else if (pick < 70) begin
        tgt_top = (sb.tbl_entries + 1 > 63) ? 63 : sb.tbl_entries + 1;
        send_request(ACT_SET, later_unit(unit_now, $urandom_range(60)),
                     1'($urandom_range(1)), TGT_W'($urandom_range(tgt_top)));
      end else if (pick < 80) begin
        unit_now = later_unit(unit_now, $urandom_range(5));
      end else begin
        send_noise();
      end
      unit_now = later_unit(unit_now, $urandom_range(2));
    end
  endtask

  initial begin
    sb           = new();
    send_idle    = 0;
    recv_stall   = 0;
    items_sent   = 0;
    cycle_count  = 0;
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_fill();
    while (items_sent < ITEM_TARGET) begin
      case (items_sent * 4 / ITEM_TARGET)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      case ($urandom_range(9))
        0, 1: run_fill();
        8, 9: repeat ($urandom_range(5, 15)) send_noise();
        default: run_scan();
      endcase
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("lifetime_buffer_allocator_top verification clean");
    end else begin
      $display("lifetime_buffer_allocator_top verification failed");
    end
    $finish;
  end

endmodule
